@@ rtl/md5bc_pkg.sv @@
// ----------------------------------------------------------------------------
// md5bc_pkg
// Types, tables and helper functions shared by the MD5 block compression
// modules.
// ----------------------------------------------------------------------------
package md5bc_pkg;

  typedef struct packed {
    logic [31:0] word;
    logic [3:0]  idx;
    logic        restart;
  } md5bc_entry_t;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [3:0] LAST_IDX = 4'd15;

  localparam logic [31:0] ADD_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] w;
    w = {x, x} << s;
    return w[63:32];
  endfunction

  // Index of the message word used by a step.
  function automatic logic [3:0] msg_idx(input logic [5:0] step);
    logic [3:0] i4;
    logic [3:0] g;
    i4 = step[3:0];
    unique case (step[5:4])
      2'd0:    g = i4;
      2'd1:    g = i4 * 4'd5 + 4'd1;
      2'd2:    g = i4 * 4'd3 + 4'd5;
      default: g = i4 * 4'd7;
    endcase
    return g;
  endfunction

endpackage

@@ rtl/md5bc_front.sv @@
// ----------------------------------------------------------------------------
// md5bc_front
// Accepts message words, tracks the position of each word within its block
// and hands tagged entries to the queue.
// ----------------------------------------------------------------------------
module md5bc_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [31:0]            in_tdata,
  input  logic                   in_tuser,
  output logic                   push,
  output md5bc_pkg::md5bc_entry_t push_entry,
  input  logic                   queue_full
);
  import md5bc_pkg::*;

  logic [3:0] cnt_r;
  logic [3:0] cnt_nxt;
  logic [3:0] idx;

  assign in_tready = !queue_full;
  assign push      = in_tvalid && in_tready;
  assign idx       = in_tuser ? 4'd0 : cnt_r;
  assign cnt_nxt   = (idx == LAST_IDX) ? 4'd0 : idx + 4'd1;

  assign push_entry.word    = in_tdata;
  assign push_entry.idx     = idx;
  assign push_entry.restart = in_tuser;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 4'd0;
    end else if (push) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ rtl/md5bc_fifo.sv @@
// ----------------------------------------------------------------------------
// md5bc_fifo
// Short queue of tagged words between the front end and the compression core.
// ----------------------------------------------------------------------------
module md5bc_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  md5bc_pkg::md5bc_entry_t push_entry,
  input  logic                    pop,
  output md5bc_pkg::md5bc_entry_t pop_entry,
  output logic                    full,
  output logic                    empty
);
  import md5bc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  md5bc_entry_t  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full      = (count_r == FULL_CNT);
  assign empty     = (count_r == '0);
  assign pop_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/md5bc_core.sv @@
// ----------------------------------------------------------------------------
// md5bc_core
// Fills the block buffer from the queue and runs the 64 MD5 steps, one step
// per cycle, then adds into the chaining words and registers the result.
// ----------------------------------------------------------------------------
module md5bc_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_empty,
  input  md5bc_pkg::md5bc_entry_t q_entry,
  output logic                    pop,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [127:0]            out_tdata
);
  import md5bc_pkg::*;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PREP,
    ST_COMP,
    ST_FINAL
  } state_t;

  state_t       state_r;
  logic [31:0]  buf_r [16];
  logic [31:0]  ch_a_r, ch_b_r, ch_c_r, ch_d_r;
  logic [31:0]  a_r, b_r, c_r, d_r;
  logic [31:0]  km_r;
  logic [5:0]   step_r;
  logic         out_valid_r;
  logic [127:0] out_data_r;

  logic [1:0]   rnd;
  logic [31:0]  f;
  logic [31:0]  sum;
  logic [31:0]  b_nxt;
  logic [5:0]   nstep;
  logic [31:0]  km_nxt;
  logic [31:0]  sum_a, sum_b, sum_c, sum_d;

  assign pop        = (state_r == ST_LOAD) && !q_empty;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign rnd = step_r[5:4];

  always_comb begin
    unique case (rnd)
      2'd0:    f = (b_r & c_r) | (~b_r & d_r);
      2'd1:    f = (b_r & d_r) | (c_r & ~d_r);
      2'd2:    f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
  end

  assign sum    = a_r + f + km_r;
  assign b_nxt  = b_r + rotl32(sum, ROT_S[{rnd, step_r[1:0]}]);
  assign nstep  = (state_r == ST_PREP) ? 6'd0 : step_r + 6'd1;
  assign km_nxt = ADD_K[nstep] + buf_r[msg_idx(nstep)];

  assign sum_a = ch_a_r + a_r;
  assign sum_b = ch_b_r + b_r;
  assign sum_c = ch_c_r + c_r;
  assign sum_d = ch_d_r + d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      out_valid_r <= 1'b0;
      step_r      <= 6'd0;
      ch_a_r      <= INIT_A;
      ch_b_r      <= INIT_B;
      ch_c_r      <= INIT_C;
      ch_d_r      <= INIT_D;
    end else begin
      if (out_valid_r && out_tready && (state_r != ST_FINAL)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_LOAD: begin
          if (!q_empty) begin
            buf_r[q_entry.idx] <= q_entry.word;
            if (q_entry.restart) begin
              ch_a_r <= INIT_A;
              ch_b_r <= INIT_B;
              ch_c_r <= INIT_C;
              ch_d_r <= INIT_D;
            end
            if (q_entry.idx == LAST_IDX) begin
              state_r <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          a_r     <= ch_a_r;
          b_r     <= ch_b_r;
          c_r     <= ch_c_r;
          d_r     <= ch_d_r;
          km_r    <= km_nxt;
          step_r  <= 6'd0;
          state_r <= ST_COMP;
        end
        ST_COMP: begin
          a_r    <= d_r;
          b_r    <= b_nxt;
          c_r    <= b_r;
          d_r    <= c_r;
          km_r   <= km_nxt;
          step_r <= nstep;
          if (step_r == 6'd63) begin
            state_r <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          if (!out_valid_r || out_tready) begin
            ch_a_r      <= sum_a;
            ch_b_r      <= sum_b;
            ch_c_r      <= sum_c;
            ch_d_r      <= sum_d;
            out_data_r  <= {sum_d, sum_c, sum_b, sum_a};
            out_valid_r <= 1'b1;
            state_r     <= ST_LOAD;
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

endmodule

@@ rtl/md5_block_compression.sv @@
// ----------------------------------------------------------------------------
// md5_block_compression
// MD5 compression function over 16-word blocks with kept chaining words.
// ----------------------------------------------------------------------------
//  Channel  Ports        Contents
//  input    in_*         tdata: message word, tuser: restart flag
//  result   out_*        tdata: digest A, B, C, D from the lowest bits up
//
//  In the core a block moves its words from the queue into the block
//  buffer, passes a set-up state, runs 64 steps on the shared step unit
//  and then adds into the chaining words.
//  The input side fills the queue while the core works, until it is full.
//  Reset clears the counters and loads the standard chaining values.
//  A waiting result stalls the core only when the next block is complete.
// ----------------------------------------------------------------------------
module md5_block_compression #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // [31:0] message_word
  input  logic         in_tuser,   // [0] restart
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata   // digest_a, digest_b, digest_c, digest_d
);
  import md5bc_pkg::*;

  md5bc_entry_t push_entry;
  md5bc_entry_t pop_entry;
  logic         push;
  logic         pop;
  logic         q_full;
  logic         q_empty;

  md5bc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push       (push),
    .push_entry (push_entry),
    .queue_full (q_full)
  );

  md5bc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .full       (q_full),
    .empty      (q_empty)
  );

  md5bc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_entry    (pop_entry),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ verif/md5_block_compression_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_block_compression_tb
// Streams message words into the MD5 block compression core with
// random gaps on the input side and random back-pressure on the digest side.
// Each digest is compared with a known value or local model of the 64-step
// compression function and the kept chaining words. A known single-block
// message and a restart in mid-block are covered before the random blocks.
// ----------------------------------------------------------------------------
module md5_block_compression_tb;

  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_WORDS = 830;
  localparam int QUIET_AFTER  = 700;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [31:0] d;
    logic [31:0] c;
    logic [31:0] b;
    logic [31:0] a;
  } digest_t;

  typedef struct packed {
    logic [31:0] word;
    logic        restart;
    logic        has_known;
    digest_t     known;
  } msg_word_t;

  localparam digest_t MD5_IV = '{d: 32'h10325476, c: 32'h98badcfe,
                                 b: 32'hefcdab89, a: 32'h67452301};

  localparam logic [31:0] SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int ROT_AMT [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                  4, 11, 16, 23, 6, 10, 15, 21};

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [31:0]  in_tdata;    // [31:0] message_word
  logic         in_tuser;    // [0] restart
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;   // digest_a, digest_b, digest_c, digest_d

  digest_t     expected_digests [$];
  msg_word_t   words_in_flight [$];
  digest_t     chain_words = MD5_IV;
  logic [31:0] block_buf [16];
  int          words_held = 0;
  int          words_sent = 0;
  int          mismatches = 0;
  int          stall_left = 0;
  int          cycle_count = 0;
  logic        quiet;

  assign quiet = (words_sent >= QUIET_AFTER);

  md5_block_compression i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic digest_t md5_compress(input digest_t chain,
                                           input logic [31:0] blk [16]);
    logic [31:0] a, b, c, d, f, t, sum;
    int          g, s;
    digest_t     res;
    a = chain.a;
    b = chain.b;
    c = chain.c;
    d = chain.d;
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = 5 * i + 1;
        end
        2: begin
          f = b ^ c ^ d;
          g = 3 * i + 5;
        end
        default: begin
          f = c ^ (b | ~d);
          g = 7 * i;
        end
      endcase
      s = ROT_AMT[(i / 16) * 4 + i % 4];
      sum = a + f + SINE_K[i] + blk[g % 16];
      t = d;
      d = c;
      c = b;
      b = b + ((sum << s) | (sum >> (32 - s)));
      a = t;
    end
    res.a = chain.a + a;
    res.b = chain.b + b;
    res.c = chain.c + c;
    res.d = chain.d + d;
    return res;
  endfunction

  // Prediction and checking share one process so that a word and a digest
  // taken at the same edge are always handled in that order.
  always @(posedge clk) begin
    msg_word_t w;
    digest_t   got;
    digest_t   want;
    if (rst_n && in_tvalid && in_tready) begin
      w = words_in_flight.pop_front();
      if (w.restart) begin
        chain_words = MD5_IV;
        words_held = 0;
      end
      block_buf[words_held] = w.word;
      if (words_held == 15) begin
        words_held = 0;
        chain_words = md5_compress(chain_words, block_buf);
        expected_digests.push_back(w.has_known ? w.known : chain_words);
      end else begin
        words_held++;
      end
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_digests.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("digest with none expected: a=%h b=%h c=%h d=%h",
                   got.a, got.b, got.c, got.d);
        end
      end else begin
        want = expected_digests.pop_front();
        if (got.a !== want.a || got.b !== want.b || got.c !== want.c ||
            got.d !== want.d) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("digest mismatch: expected a=%h b=%h c=%h d=%h",
                     want.a, want.b, want.c, want.d);
            $display("                 actual   a=%h b=%h c=%h d=%h",
                     got.a, got.b, got.c, got.d);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_word(input logic [31:0] word, input logic restart,
                           input logic has_known, input digest_t known);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
    end
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    words_in_flight.push_back('{word: word, restart: restart,
                                has_known: has_known, known: known});
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= restart;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  initial begin
    msg_word_t   rows [20];
    int          len;
    logic        first_restart;
    logic        force_restart;
    logic [31:0] w;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    // The one-block message "abc" straight after reset, then a new block
    // that is dropped by a restart on its fourth word.
    rows = '{
      '{32'h80636261, 1'b0, 1'b0, '0},
      '{32'h00000000, 1'b0, 1'b0, '0},
      '{32'h00000000, 1'b0, 1'b0, '0},
      '{32'h00000000, 1'b0, 1'b0, '0},
      '{32'h00000000, 1'b0, 1'b0, '0},
      '{32'h00000000, 1'b0, 1'b0, '0},
      '{32'h00000000, 1'b0, 1'b0, '0},
      '{32'h00000000, 1'b0, 1'b0, '0},
      '{32'h00000000, 1'b0, 1'b0, '0},
      '{32'h00000000, 1'b0, 1'b0, '0},
      '{32'h00000000, 1'b0, 1'b0, '0},
      '{32'h00000000, 1'b0, 1'b0, '0},
      '{32'h00000000, 1'b0, 1'b0, '0},
      '{32'h00000000, 1'b0, 1'b0, '0},
      '{32'h00000018, 1'b0, 1'b0, '0},
      '{32'h00000000, 1'b0, 1'b1,
        '{d: 32'h727fe128, c: 32'h7d3f96d6, b: 32'hb04fd23c, a: 32'h98500190}},
      '{32'hffffffff, 1'b0, 1'b0, '0},
      '{32'h00000000, 1'b0, 1'b0, '0},
      '{32'hffffffff, 1'b0, 1'b0, '0},
      '{32'hffffffff, 1'b1, 1'b0, '0}
    };
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      send_word(rows[i].word, rows[i].restart, rows[i].has_known, rows[i].known);
    end

    // Hold the input off until the core has handed over every digest.
    in_tvalid <= 1'b0;
    while (expected_digests.size() != 0) @(posedge clk);

    // Mostly whole blocks; now and then a cut-off block, after which the
    // next block starts with a restart.
    force_restart = 1'b1;
    while (words_sent < $size(rows) + RANDOM_WORDS || force_restart) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 15) : 16;
      first_restart = force_restart | 1'($urandom_range(0, 1));
      for (int k = 0; k < len; k++) begin
        case ($urandom_range(0, 9))
          0:       w = '0;
          1:       w = '1;
          2:       w = 32'h1 << $urandom_range(0, 31);
          default: w = $urandom();
        endcase
        send_word(w, (k == 0) ? first_restart : 1'b0, 1'b0, '0);
      end
      force_restart = (len != 16);
    end

    in_tvalid <= 1'b0;
    while (expected_digests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_digests.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
